/* rtl/core/epoch_seconds_to_calendar_unit_macros.svh */
// Assertion macros for the epoch seconds to calendar unit.
`ifndef EPOCH_SECONDS_TO_CALENDAR_UNIT_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ESC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ESC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/esc_pkg.sv */
package esc_pkg;

  localparam logic [25:0] Recip675      = 26'd50903316;
  localparam int          Recip675Shift = 35;
  localparam logic [15:0] Recip15       = 16'd34953;
  localparam int          Recip15Shift  = 19;
  localparam logic [16:0] Recip1461     = 17'd91868;
  localparam int          Recip1461Shift = 27;
  localparam logic [12:0] Recip7        = 13'd4682;
  localparam int          Recip7Shift   = 15;

  localparam logic [9:0]  SecPerDayDiv128 = 10'd675;
  localparam logic [15:0] DaysTo1970      = 16'd731;
  localparam logic [10:0] DaysPerQuad     = 11'd1461;
  localparam logic [11:0] BaseYear        = 12'd1968;
  localparam logic [3:0]  MonthFeb        = 4'd2;
  localparam int          NumStages       = 11;

  typedef logic [8:0] doy_t;
  typedef logic [3:0] month_idx_t;

  function automatic doy_t month_start(input logic leap, input month_idx_t idx);
    doy_t base;
    base = '0;
    unique case (idx)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && idx >= 4'd2 && idx <= 4'd11) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

  function automatic logic [2:0] month_shift(input month_idx_t idx);
    logic [2:0] s;
    s = '0;
    unique case (idx)
      4'd0:    s = 3'd0;
      4'd1:    s = 3'd3;
      4'd2:    s = 3'd2;
      4'd3:    s = 3'd5;
      4'd4:    s = 3'd0;
      4'd5:    s = 3'd3;
      4'd6:    s = 3'd5;
      4'd7:    s = 3'd1;
      4'd8:    s = 3'd4;
      4'd9:    s = 3'd6;
      4'd10:   s = 3'd2;
      4'd11:   s = 3'd4;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

endpackage

/* rtl/core/epoch_seconds_to_calendar_unit.sv */
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00, shifted by the
// signed hour offset in cfg_utc_offset_hours (sum wraps modulo 2^32), into
// second, minute, hour, day of month, month, year and weekday (0 is Sunday).
// Every year divisible by four is a leap year, 2100 included. The datapath is
// an eleven-stage pipeline of constant-reciprocal multiplies: one item enters
// per cycle unless the pipeline stalls. When a finished result is held back
// by out_ready, the whole pipeline stalls and in_ready drops. The offset
// register takes effect for items transferred after the write and must only
// be changed while the pipeline is empty.
`include "epoch_seconds_to_calendar_unit_macros.svh"

module epoch_seconds_to_calendar_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic signed [4:0] cfg_utc_offset_hours,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [31:0]       in_epoch_seconds,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [5:0]        out_second_out,
  output logic [5:0]        out_minute_out,
  output logic [4:0]        out_hour_out,
  output logic [4:0]        out_day_of_month,
  output logic [3:0]        out_month_out,
  output logic [11:0]       out_year_out,
  output logic [2:0]        out_weekday
);

  localparam int Last = esc_pkg::NumStages - 1;

  logic signed [4:0]  offset_r;
  logic [Last:0]      v_r;
  logic [Last:0]      v_nxt;
  logic               en;

  logic signed [31:0] off_ext;
  logic [31:0]        off_sec;

  logic [31:0] t1_r, t2_r, t3_r;
  logic [50:0] p2_r;
  logic [15:0] dq3_r;
  logic [25:0] m3_r;
  logic [16:0] secs4_r, secs5_r;
  logic [15:0] d4_r, d5_r;
  logic [30:0] pm5_r;
  logic [32:0] pq5_r;
  logic [10:0] md6_r, md7_r;
  logic [5:0]  sec6_r, sec7_r, sec8_r, sec9_r, sec10_r;
  logic [5:0]  q6_r;
  logic [10:0] r6_r;
  logic [24:0] ph7_r;
  esc_pkg::doy_t doy7_r;
  logic [11:0] year7_r, year8_r, year9_r, year10_r;
  logic        leap7_r;
  logic [4:0]  hour8_r, hour9_r, hour10_r;
  logic [5:0]  min8_r, min9_r, min10_r;
  esc_pkg::month_idx_t midx8_r;
  logic [4:0]  day8_r, day9_r, day10_r;
  logic [3:0]  month9_r, month10_r;
  logic [11:0] s9_r, s10_r;
  logic [24:0] p10_r;

  logic [5:0]  sec_r, min_r;
  logic [4:0]  hour_r, day_r;
  logic [3:0]  month_r;
  logic [11:0] year_r;
  logic [2:0]  wday_r;

  logic [15:0] dq3;
  logic [24:0] rem4_full;
  logic [10:0] rem4;
  logic        fix4;
  logic [9:0]  remc4;
  logic [15:0] days4;
  logic [10:0] md6;
  logic [16:0] md60;
  logic [16:0] sec6_full;
  logic [5:0]  q6;
  logic [15:0] q1461;
  logic [15:0] r6_full;
  logic [10:0] rr7;
  logic [1:0]  yo7;
  esc_pkg::doy_t doy7;
  logic [4:0]  hr8;
  logic [10:0] hr60;
  logic [10:0] min8_full;
  esc_pkg::month_idx_t cnt8;
  esc_pkg::doy_t day8_full;
  logic [11:0] y9;
  logic [11:0] c100;
  logic [11:0] c400;
  logic [11:0] s9;
  logic [11:0] q7x7;
  logic [11:0] w11_full;

  logic        time_ok;
  logic        date_ok;

  assign cfg_ready = 1'b1;
  assign en        = !v_r[Last] || out_ready;
  assign in_ready  = en;
  assign v_nxt     = {v_r[Last-1:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      v_r      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        offset_r <= cfg_utc_offset_hours;
      end
      if (en) begin
        v_r <= v_nxt;
      end
    end
  end

  always_comb begin
    off_ext = 32'(offset_r);
    off_sec = 32'(off_ext * 32'sd3600);

    dq3       = p2_r[50:esc_pkg::Recip675Shift];
    rem4_full = t3_r[31:7] - m3_r[24:0];
    rem4      = rem4_full[10:0];
    fix4      = rem4 >= 11'(esc_pkg::SecPerDayDiv128);
    remc4     = fix4 ? 10'(rem4 - 11'(esc_pkg::SecPerDayDiv128)) : rem4[9:0];
    days4     = dq3_r + 16'(fix4);

    md6       = pm5_r[29:esc_pkg::Recip15Shift];
    md60      = 17'(md6) * 17'd60;
    sec6_full = secs5_r - md60;
    q6        = pq5_r[32:esc_pkg::Recip1461Shift];
    q1461     = 16'(q6) * 16'(esc_pkg::DaysPerQuad);
    r6_full   = d5_r - q1461;

    rr7  = r6_r - 11'd366;
    yo7  = 2'd0;
    doy7 = r6_r[8:0];
    if (r6_r >= 11'd366) begin
      if (rr7 >= 11'd730) begin
        yo7  = 2'd3;
        doy7 = 9'(rr7 - 11'd730);
      end else if (rr7 >= 11'd365) begin
        yo7  = 2'd2;
        doy7 = 9'(rr7 - 11'd365);
      end else begin
        yo7  = 2'd1;
        doy7 = rr7[8:0];
      end
    end

    hr8       = ph7_r[23:esc_pkg::Recip15Shift];
    hr60      = 11'(hr8) * 11'd60;
    min8_full = md7_r - hr60;
    cnt8      = '0;
    for (int k = 1; k < 12; k++) begin
      if (doy7_r >= esc_pkg::month_start(leap7_r, 4'(k))) begin
        cnt8 = cnt8 + 4'd1;
      end
    end
    day8_full = doy7_r - esc_pkg::month_start(leap7_r, cnt8) + 9'd1;

    y9   = year8_r - 12'(midx8_r < 4'd2);
    c100 = (y9 >= 12'd2100) ? 12'd21 : ((y9 >= 12'd2000) ? 12'd20 : 12'd19);
    c400 = (y9 >= 12'd2000) ? 12'd5 : 12'd4;
    s9   = y9 + (y9 >> 2) - c100 + c400 + 12'(esc_pkg::month_shift(midx8_r))
           + 12'(day8_r);

    q7x7     = 12'(p10_r[24:esc_pkg::Recip7Shift]) * 12'd7;
    w11_full = s10_r - q7x7;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r <= in_epoch_seconds + off_sec;

      p2_r <= 51'(t1_r[31:7]) * 51'(esc_pkg::Recip675);
      t2_r <= t1_r;

      dq3_r <= dq3;
      m3_r  <= 26'(dq3) * 26'(esc_pkg::SecPerDayDiv128);
      t3_r  <= t2_r;

      secs4_r <= {remc4, t3_r[6:0]};
      d4_r    <= days4 + esc_pkg::DaysTo1970;

      pm5_r   <= 31'(secs4_r[16:2]) * 31'(esc_pkg::Recip15);
      pq5_r   <= 33'(d4_r) * 33'(esc_pkg::Recip1461);
      secs5_r <= secs4_r;
      d5_r    <= d4_r;

      md6_r  <= md6;
      sec6_r <= sec6_full[5:0];
      q6_r   <= q6;
      r6_r   <= r6_full[10:0];

      ph7_r   <= 25'(md6_r[10:2]) * 25'(esc_pkg::Recip15);
      md7_r   <= md6_r;
      sec7_r  <= sec6_r;
      doy7_r  <= doy7;
      year7_r <= esc_pkg::BaseYear + 12'({q6_r, 2'b00}) + 12'(yo7);
      leap7_r <= yo7 == 2'd0;

      hour8_r <= hr8;
      min8_r  <= min8_full[5:0];
      sec8_r  <= sec7_r;
      midx8_r <= cnt8;
      day8_r  <= day8_full[4:0];
      year8_r <= year7_r;

      s9_r     <= s9;
      month9_r <= midx8_r + 4'd1;
      day9_r   <= day8_r;
      year9_r  <= year8_r;
      hour9_r  <= hour8_r;
      min9_r   <= min8_r;
      sec9_r   <= sec8_r;

      p10_r     <= 25'(s9_r) * 25'(esc_pkg::Recip7);
      s10_r     <= s9_r;
      month10_r <= month9_r;
      day10_r   <= day9_r;
      year10_r  <= year9_r;
      hour10_r  <= hour9_r;
      min10_r   <= min9_r;
      sec10_r   <= sec9_r;

      wday_r  <= w11_full[2:0];
      month_r <= month10_r;
      day_r   <= day10_r;
      year_r  <= year10_r;
      hour_r  <= hour10_r;
      min_r   <= min10_r;
      sec_r   <= sec10_r;
    end
  end

  assign out_valid        = v_r[Last];
  assign out_second_out   = sec_r;
  assign out_minute_out   = min_r;
  assign out_hour_out     = hour_r;
  assign out_day_of_month = day_r;
  assign out_month_out    = month_r;
  assign out_year_out     = year_r;
  assign out_weekday      = wday_r;

  assign time_ok = (out_second_out < 6'd60) && (out_minute_out < 6'd60) &&
                   (out_hour_out < 5'd24);
  assign date_ok = (out_day_of_month != 5'd0) && (out_month_out != 4'd0) &&
                   (out_month_out <= 4'd12) && (out_year_out >= 12'd1970) &&
                   (out_year_out <= 12'd2106) && (out_weekday < 3'd7);

  `ESC_ASSERT_SAME(a_time_range, out_valid, time_ok, "time of day out of range")
  `ESC_ASSERT_SAME(a_date_range, out_valid, date_ok, "date out of range")
  `ESC_ASSERT_SAME(a_feb_len, out_valid && (out_month_out == esc_pkg::MonthFeb), out_day_of_month <= 5'd29, "February day out of range")
  `ESC_ASSERT_NEXT(a_stall_hold, !en, $stable(v_r), "pipeline valid bits moved during a stall")

endmodule
